@@ rtl/fclp_pkg.sv @@
// ----------------------------------------------------------------------------
// fclp_pkg
// Shared types, codes and constants of the configuration loader protocol.
// ----------------------------------------------------------------------------
package fclp_pkg;

  localparam int CNT_BITS_DEF = 32;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = 1;
  localparam int QCNT_W       = 2;

  // Host characters
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_V = 8'h56;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] HDR_MARK = 8'hAA;
  localparam logic [31:0] HDR_BYTES = 32'd5;

  // Result actions
  localparam logic [3:0] ACT_REPLY    = 4'd0;
  localparam logic [3:0] ACT_ERASE    = 4'd1;
  localparam logic [3:0] ACT_FWRITE   = 4'd2;
  localparam logic [3:0] ACT_FSTART   = 4'd3;
  localparam logic [3:0] ACT_FBYTE    = 4'd4;
  localparam logic [3:0] ACT_FFINISH  = 4'd5;
  localparam logic [3:0] ACT_READBACK = 4'd6;
  localparam logic [3:0] ACT_LOADF    = 4'd7;
  localparam logic [3:0] ACT_ENTER    = 4'd8;
  localparam logic [3:0] ACT_RESUME   = 4'd9;

  // Job codes passed from front to back
  localparam logic [3:0] J_ENTER      = 4'd0;
  localparam logic [3:0] J_CMD_ACK    = 4'd1;
  localparam logic [3:0] J_ERASE_CMD  = 4'd2;
  localparam logic [3:0] J_SIZE_FPGA  = 4'd3;
  localparam logic [3:0] J_SIZE_FLASH = 4'd4;
  localparam logic [3:0] J_FLASH      = 4'd5;
  localparam logic [3:0] J_FLASH_DONE = 4'd6;
  localparam logic [3:0] J_FPGA       = 4'd7;
  localparam logic [3:0] J_FPGA_DONE  = 4'd8;
  localparam logic [3:0] J_READBACK   = 4'd9;
  localparam logic [3:0] J_LOADF      = 4'd10;

  typedef struct packed {
    logic [3:0]  jtype;
    logic [7:0]  data;
    logic [31:0] val;   // flash address or readback length
    logic [31:0] size;  // header size for a finished flash load
  } job_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  out_byte;
    logic [31:0] flash_address;
    logic [31:0] readback_length;
    logic        last;
  } rslt_t;

endpackage

@@ rtl/fclp_front.sv @@
// ----------------------------------------------------------------------------
// fclp_front
// Protocol state and command decode; emits one job per beat that has results.
// ----------------------------------------------------------------------------
module fclp_front #(
  parameter int COUNT_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic          kind,
  input  logic [7:0]    host_byte,
  output logic          job_vld,
  output fclp_pkg::job_t job
);
  import fclp_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SIZE   = 3'd1;
  localparam logic [2:0] PH_FLASH  = 3'd2;
  localparam logic [2:0] PH_FPGA   = 3'd3;
  localparam logic [2:0] PH_VERIFY = 3'd4;
  localparam logic [2:0] PH_LOADF  = 3'd5;

  logic                  mode_r, mode_nxt;
  logic [2:0]            phase_r, phase_nxt;
  logic                  to_fpga_r, to_fpga_nxt;
  logic                  verify_r, verify_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0] len_r, len_nxt;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [31:0]           shifted;
  logic [31:0]           cnt_plus5;

  assign cnt_inc   = cnt_r + 1'b1;
  assign shifted   = {24'd0, host_byte} << {cnt_r[1:0], 3'b000};
  assign cnt_plus5 = 32'(cnt_r) + HDR_BYTES;

  always_comb begin
    mode_nxt    = mode_r;
    phase_nxt   = phase_r;
    to_fpga_nxt = to_fpga_r;
    verify_nxt  = verify_r;
    cnt_nxt     = cnt_r;
    len_nxt     = len_r;
    job_vld     = 1'b0;
    job.jtype   = J_ENTER;
    job.data    = host_byte;
    job.val     = '0;
    job.size    = '0;
    if (kind) begin
      mode_nxt  = 1'b1;
      phase_nxt = PH_IDLE;
      job_vld   = 1'b1;
    end else if (mode_r) begin
      case (phase_r)
        PH_IDLE: begin
          cnt_nxt = '0;
          len_nxt = '0;
          if (host_byte == CH_F || host_byte == CH_V) begin
            to_fpga_nxt = 1'b0;
            verify_nxt  = (host_byte == CH_V);
            phase_nxt   = PH_SIZE;
            job_vld     = 1'b1;
            job.jtype   = J_CMD_ACK;
          end else if (host_byte == CH_R) begin
            to_fpga_nxt = 1'b1;
            phase_nxt   = PH_SIZE;
            job_vld     = 1'b1;
            job.jtype   = J_CMD_ACK;
          end else if (host_byte == CH_E) begin
            job_vld   = 1'b1;
            job.jtype = J_ERASE_CMD;
          end
        end
        PH_SIZE: begin
          len_nxt = len_r | shifted[COUNT_BITS-1:0];
          cnt_nxt = cnt_inc;
          if (cnt_inc > COUNT_BITS'(3)) begin
            cnt_nxt = '0;
            job_vld = 1'b1;
            if (to_fpga_r) begin
              phase_nxt = PH_FPGA;
              job.jtype = J_SIZE_FPGA;
            end else begin
              phase_nxt = PH_FLASH;
              job.jtype = J_SIZE_FLASH;
            end
          end
        end
        PH_FLASH: begin
          cnt_nxt   = cnt_inc;
          job_vld   = 1'b1;
          job.val   = cnt_plus5;
          job.size  = 32'(cnt_inc) + HDR_BYTES;
          job.jtype = J_FLASH;
          if (cnt_inc == len_r) begin
            job.jtype = J_FLASH_DONE;
            phase_nxt = verify_r ? PH_VERIFY : PH_LOADF;
          end
        end
        PH_FPGA: begin
          cnt_nxt   = cnt_inc;
          job_vld   = 1'b1;
          job.jtype = J_FPGA;
          if (cnt_inc == len_r) begin
            job.jtype = J_FPGA_DONE;
            mode_nxt  = 1'b0;
            phase_nxt = PH_IDLE;
          end
        end
        PH_VERIFY: begin
          if (host_byte == CH_S) begin
            cnt_nxt   = cnt_plus5[COUNT_BITS-1:0];
            job_vld   = 1'b1;
            job.jtype = J_READBACK;
            job.val   = cnt_plus5;
            phase_nxt = PH_LOADF;
          end
        end
        default: begin
          if (host_byte == CH_L) begin
            job_vld   = 1'b1;
            job.jtype = J_LOADF;
            mode_nxt  = 1'b0;
            phase_nxt = PH_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      phase_r   <= PH_IDLE;
      to_fpga_r <= 1'b0;
      verify_r  <= 1'b0;
      cnt_r     <= '0;
      len_r     <= '0;
    end else if (acc) begin
      mode_r    <= mode_nxt;
      phase_r   <= phase_nxt;
      to_fpga_r <= to_fpga_nxt;
      verify_r  <= verify_nxt;
      cnt_r     <= cnt_nxt;
      len_r     <= len_nxt;
    end
  end

endmodule

@@ rtl/fclp_queue.sv @@
// ----------------------------------------------------------------------------
// fclp_queue
// Short job queue between the decode front and the result sequencer.
// ----------------------------------------------------------------------------
module fclp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fclp_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output fclp_pkg::job_t head
);
  import fclp_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/fclp_back.sv @@
// ----------------------------------------------------------------------------
// fclp_back
// Result sequencer: expands each job into its result beats, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module fclp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  fclp_pkg::job_t  q_head,
  output logic            q_pop,
  output logic            res_vld,
  output fclp_pkg::rslt_t res,
  input  logic            res_rdy
);
  import fclp_pkg::*;

  job_t       cur_r;
  logic       cur_vld_r;
  logic [2:0] step_r;
  logic       out_vld_r;
  rslt_t      out_r;
  rslt_t      gen;
  logic       slot, emit, finish;
  logic [1:0] hdr_idx;
  logic [31:0] hdr_shift;

  assign hdr_idx   = 2'(step_r - 3'd1);
  assign hdr_shift = cur_r.size >> {hdr_idx, 3'b000};

  always_comb begin
    gen.action          = ACT_REPLY;
    gen.out_byte        = '0;
    gen.flash_address   = '0;
    gen.readback_length = '0;
    gen.last            = 1'b1;
    case (cur_r.jtype)
      J_ENTER: gen.action = ACT_ENTER;
      J_CMD_ACK: gen.out_byte = CH_R;
      J_ERASE_CMD, J_SIZE_FPGA, J_SIZE_FLASH: begin
        if (step_r == 3'd0) begin
          gen.action = (cur_r.jtype == J_SIZE_FPGA) ? ACT_FSTART : ACT_ERASE;
          gen.last   = 1'b0;
        end else begin
          gen.out_byte = (cur_r.jtype == J_ERASE_CMD) ? CH_D : CH_O;
        end
      end
      J_FLASH: begin
        gen.action        = ACT_FWRITE;
        gen.out_byte      = cur_r.data;
        gen.flash_address = cur_r.val;
      end
      J_FLASH_DONE: begin
        gen.last = 1'b0;
        case (step_r)
          3'd0: begin
            gen.action        = ACT_FWRITE;
            gen.out_byte      = cur_r.data;
            gen.flash_address = cur_r.val;
          end
          3'd1, 3'd2, 3'd3, 3'd4: begin
            gen.action        = ACT_FWRITE;
            gen.out_byte      = hdr_shift[7:0];
            gen.flash_address = 32'(step_r);
          end
          3'd5: begin
            gen.action   = ACT_FWRITE;
            gen.out_byte = HDR_MARK;
          end
          default: begin
            gen.out_byte = CH_D;
            gen.last     = 1'b1;
          end
        endcase
      end
      J_FPGA: begin
        gen.action   = ACT_FBYTE;
        gen.out_byte = cur_r.data;
      end
      J_FPGA_DONE: begin
        gen.last = 1'b0;
        case (step_r)
          3'd0: begin
            gen.action   = ACT_FBYTE;
            gen.out_byte = cur_r.data;
          end
          3'd1: gen.action = ACT_FFINISH;
          3'd2: gen.action = ACT_RESUME;
          default: begin
            gen.out_byte = CH_D;
            gen.last     = 1'b1;
          end
        endcase
      end
      J_READBACK: begin
        gen.action          = ACT_READBACK;
        gen.readback_length = cur_r.val;
      end
      default: begin
        gen.last = 1'b0;
        case (step_r)
          3'd0: gen.action = ACT_LOADF;
          3'd1: gen.out_byte = CH_D;
          default: begin
            gen.action = ACT_RESUME;
            gen.last   = 1'b1;
          end
        endcase
      end
    endcase
  end

  assign slot    = !out_vld_r || res_rdy;
  assign emit    = cur_vld_r && slot;
  assign finish  = emit && gen.last;
  assign q_pop   = !q_empty && (!cur_vld_r || finish);
  assign res_vld = out_vld_r;
  assign res     = out_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= gen;
    end
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      step_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (res_rdy) begin
        out_vld_r <= 1'b0;
      end
      if (q_pop) begin
        cur_vld_r <= 1'b1;
        step_r    <= '0;
      end else if (finish) begin
        cur_vld_r <= 1'b0;
      end else if (emit) begin
        step_r <= step_r + 1'b1;
      end
    end
  end

endmodule

@@ rtl/fpga_config_loader_protocol.sv @@
// ----------------------------------------------------------------------------
// fpga_config_loader_protocol
// Loader protocol engine: host bytes in, host replies and device commands out.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                   | tuser | tlast
//  in_     | in  | [7:0] host_byte                         | kind  | -
//  out_    | out | action, out_byte, flash_address, rb_len | -     | last
//
//  One input beat per cycle while the job queue has room.
//  The sequencer sends one result beat per cycle unless out_tready stalls it;
//  a beat causes 0 to 7 results, and the final flash data byte causes 7.
//  Synchronous active-low reset leaves service mode and returns to idle phase.
//  Output stalls fill the two-entry queue, then in_tready drops.
// ----------------------------------------------------------------------------
module fpga_config_loader_protocol #(
  parameter int COUNT_BITS = fclp_pkg::CNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] host_byte
  input  logic [0:0]  in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [3:0] action, [11:4] out_byte,
                                  // [43:12] flash_address, [75:44] readback_length
  output logic        out_tlast
);
  import fclp_pkg::*;

  logic  acc;
  logic  job_vld;
  job_t  job;
  logic  q_full, q_empty, q_pop;
  job_t  q_head;
  rslt_t res;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  fclp_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .kind     (in_tuser[0]),
    .host_byte(in_tdata),
    .job_vld  (job_vld),
    .job      (job)
  );

  fclp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (acc && job_vld),
    .push_job(job),
    .pop     (q_pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (q_head)
  );

  fclp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_empty(q_empty),
    .q_head (q_head),
    .q_pop  (q_pop),
    .res_vld(out_tvalid),
    .res    (res),
    .res_rdy(out_tready)
  );

  assign out_tdata = {4'd0, res.readback_length, res.flash_address, res.out_byte, res.action};
  assign out_tlast = res.last;

endmodule
